// ===== rtl/core/odd_pkg.sv =====
// ----------------------------------------------------------------------------
// Onset delay detector package
// Shared widths, register indexes, result codes, word types and the
// controller state type.
// ----------------------------------------------------------------------------
package odd_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int PEAK_BITS     = SAMPLE_BITS;
  localparam int INDEX_BITS    = 14;
  localparam int FRAC_BITS     = 17;
  localparam int FRAC_SHIFT    = 16;
  localparam int TARGET_BITS   = PEAK_BITS + FRAC_BITS;
  localparam int CFG_DATA_BITS = 24;

  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t CFG_THRESHOLD = 1'b0;
  localparam cfg_index_t CFG_MIN_PEAK  = 1'b1;

  localparam logic [FRAC_BITS-1:0] THRESHOLD_RESET = 17'd49152;
  localparam logic [PEAK_BITS-1:0] MIN_PEAK_RESET  = 24'd8;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_WEAK  = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } sample_word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] delay_index;
    logic [PEAK_BITS-1:0]  peak_value;
    logic [1:0]            status;
    logic                  truncated;
  } result_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_TARGET,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic capture;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/odd_ram.sv =====
// ----------------------------------------------------------------------------
// Onset delay detector sample RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module odd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/odd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Onset delay detector controller
// Sequences loading, threshold set-up, the store scan and result hand-off.
// ----------------------------------------------------------------------------
module odd_ctrl import odd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  input  logic       sample_last,
  input  dp_status_t status,
  output logic       sample_stall,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (sample_valid && sample_last) begin
          state_next = ST_TARGET;
        end
      end
      ST_TARGET: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    cmd          = '0;
    unique case (state)
      ST_LOAD: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid;
      end
      ST_TARGET: begin
        cmd.start = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.capture = status.scan_done;
      end
      ST_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
        sample_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/odd_datapath.sv =====
// ----------------------------------------------------------------------------
// Onset delay detector datapath
// Configuration registers, sample store, peak tracking, threshold product,
// scan pointer and compare, and the result output register.
// ----------------------------------------------------------------------------
module odd_datapath import odd_pkg::*; #(
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  sample_word_t             sample_word,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_word_t             result_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_COUNT = CW'(DEPTH);

  logic [FRAC_BITS-1:0]   threshold_fraction;
  logic [PEAK_BITS-1:0]   minimum_peak;
  logic [PEAK_BITS-1:0]   running_peak;
  logic [CW-1:0]          fill_count;
  logic                   overflow_seen;
  logic [TARGET_BITS-1:0] target;
  logic [TARGET_BITS-1:0] target_next;
  logic                   below_min;
  logic [CW-1:0]          rd_ptr;
  logic                   rd_pend;
  logic [AW-1:0]          rd_idx;
  logic [1:0]             res_status;
  logic [AW-1:0]          res_idx;

  logic [SAMPLE_BITS-1:0]      raw;
  logic [SAMPLE_BITS-1:0]      mag;
  logic                        has_room;
  logic                        wr_en;
  logic                        can_issue;
  logic                        rd_en;
  logic [SAMPLE_BITS-1:0]      rd_data;
  logic [TARGET_BITS-1:0]      scaled;
  logic                        hit;
  logic [INDEX_BITS+AW-1:0]    idx_wide;

  // Magnitude of the incoming sample; the most negative code gives 2^(N-1).
  assign raw = sample_word.sample;
  assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

  assign has_room  = fill_count < DEPTH_COUNT;
  assign wr_en     = cmd.load && has_room;
  assign can_issue = rd_ptr < fill_count;
  assign rd_en     = cmd.scan && can_issue;

  assign target_next = TARGET_BITS'(running_peak) * TARGET_BITS'(threshold_fraction);
  assign scaled      = TARGET_BITS'({rd_data, {FRAC_SHIFT{1'b0}}});
  assign hit         = rd_pend && (scaled >= target);

  assign status.scan_done = below_min || hit || (!rd_pend && !can_issue);
  assign status.out_free  = !result_valid || !result_stall;

  assign idx_wide = {{INDEX_BITS{1'b0}}, res_idx};

  odd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data (mag),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_fraction <= THRESHOLD_RESET;
      minimum_peak       <= MIN_PEAK_RESET;
      running_peak       <= '0;
      fill_count         <= '0;
      overflow_seen      <= 1'b0;
      rd_ptr             <= '0;
      rd_pend            <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_THRESHOLD: threshold_fraction <= cfg_data[FRAC_BITS-1:0];
          CFG_MIN_PEAK:  minimum_peak       <= cfg_data[PEAK_BITS-1:0];
          default:       minimum_peak       <= minimum_peak;
        endcase
      end

      if (cmd.load) begin
        if (has_room) begin
          fill_count <= fill_count + 1'b1;
          if (mag > running_peak) begin
            running_peak <= mag;
          end
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      if (cmd.emit) begin
        running_peak  <= '0;
        fill_count    <= '0;
        overflow_seen <= 1'b0;
      end

      if (cmd.start) begin
        rd_ptr  <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend <= can_issue;
        if (can_issue) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end

      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target    <= target_next;
      below_min <= running_peak < minimum_peak;
    end

    if (rd_en) begin
      rd_idx <= rd_ptr[AW-1:0];
    end

    if (cmd.capture) begin
      if (below_min) begin
        res_status <= STATUS_WEAK;
        res_idx    <= '0;
      end else if (hit) begin
        res_status <= STATUS_FOUND;
        res_idx    <= rd_idx;
      end else begin
        res_status <= STATUS_NONE;
        res_idx    <= '0;
      end
    end

    if (cmd.emit) begin
      result_word.delay_index <= idx_wide[INDEX_BITS-1:0];
      result_word.peak_value  <= running_peak;
      result_word.status      <= res_status;
      result_word.truncated   <= overflow_seen;
    end
  end

endmodule

// ===== rtl/core/onset_delay_detector_core.sv =====
// ----------------------------------------------------------------------------
// Onset delay detector core
// Stores one window of samples, finds its peak and the first sample whose
// magnitude reaches a programmable fraction of that peak.
// ----------------------------------------------------------------------------
// Sample words are taken one per clock while the block is loading, and each
// magnitude is written to a single-port-write sample RAM of DEPTH entries
// while the running peak is updated. After the word marked last, the block
// stalls its input: the target state forms the threshold product peak times
// fraction, then the RAM is read back one entry per cycle from index zero,
// and the done state hands the result to the output register once it is
// free. A finished result sits in the output register, so loading of the
// next window starts while it waits.
// Samples beyond DEPTH are dropped and reported through the truncated flag.
// The RAM has no reset; only entries written in the current window are read.
// ----------------------------------------------------------------------------
module onset_delay_detector_core import odd_pkg::*; #(
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  sample_word_t             sample_word,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_word_t             result_word
);

  // Commands from the controller and status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  odd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_last  (sample_word.last),
    .status       (status),
    .sample_stall (sample_stall),
    .cmd          (cmd)
  );

  // The datapath owns the configuration registers, the sample store and the
  // output register that parts the result side from the loading side.
  odd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_word  (sample_word),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

// ===== test/onset_delay_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// Onset delay detector core testbench
// Drives windows of signed sample words into the core and checks every
// result word against a cycle-independent predictor of the onset search.
// Both handshake sides insert random gaps, and the registers are reprogrammed
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module onset_delay_detector_core_tb import odd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16384;
  localparam longint unsigned FRAC_ONE = 64'd65536;

  // Register values the core comes out of reset with.
  localparam logic [FRAC_BITS-1:0] FRACTION_AFTER_RESET = 17'd49152;
  localparam logic [PEAK_BITS-1:0] MIN_PEAK_AFTER_RESET = 24'd8;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 24'h7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 24'h800000;

  typedef struct {
    sample_word_t word;
    int unsigned  gap;
    bit           drain;
  } queued_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write_en = 1'b0;
  cfg_index_t               cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  sample_word_t             sample_word = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_word_t             result_word;

  // Words waiting to be offered, and the results the predictor still owes.
  queued_word_t sample_backlog[$];
  result_word_t awaited_results[$];

  // Predictor state: its own copy of the window and of the registers.
  logic [FRAC_BITS-1:0] model_fraction = FRACTION_AFTER_RESET;
  logic [PEAK_BITS-1:0] model_min_peak = MIN_PEAK_AFTER_RESET;
  logic [PEAK_BITS-1:0] magnitude_store [DEPTH];
  logic [PEAK_BITS-1:0] window_peak = '0;
  int unsigned          window_fill = 0;
  bit                   window_overflow = 1'b0;

  int unsigned error_count = 0;
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned register_writes = 0;
  int unsigned windows_checked = 0;
  int unsigned onsets_seen = 0;
  int unsigned weak_seen = 0;
  int unsigned uncrossed_seen = 0;
  int unsigned truncated_seen = 0;

  // Receiver runs without stalls while this is set.
  bit rx_quiet = 1'b0;

  int unsigned  idle_count = 0;
  int unsigned  hold_count = 0;
  queued_word_t next_word;
  result_word_t want;

  onset_delay_detector_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Takes one accepted sample word into the predicted window. On the word
  // marked last it works out the window's result and clears the window; the
  // store itself keeps its contents, as the core's RAM does.
  function automatic void absorb_sample(sample_word_t w);
    logic [PEAK_BITS-1:0] raw;
    logic [PEAK_BITS-1:0] mag;
    longint unsigned      target;
    result_word_t         r;
    raw = w.sample;
    mag = raw[PEAK_BITS-1] ? (~raw + 1'b1) : raw;
    if (window_fill < DEPTH) begin
      magnitude_store[window_fill] = mag;
      window_fill++;
      if (mag > window_peak) begin
        window_peak = mag;
      end
    end else begin
      // Words past the end of the store are lost and do not feed the peak.
      window_overflow = 1'b1;
    end
    if (!w.last) begin
      return;
    end
    r.delay_index = '0;
    r.peak_value = window_peak;
    r.truncated = window_overflow;
    if (window_peak < model_min_peak) begin
      r.status = STATUS_WEAK;
    end else begin
      // Exact comparison |x| * 2^16 >= peak * fraction; no crossing is only
      // possible when the fraction is above one.
      target = 64'(window_peak) * 64'(model_fraction);
      r.status = STATUS_NONE;
      for (int i = 0; i < window_fill; i++) begin
        if ((64'(magnitude_store[i]) << FRAC_SHIFT) >= target) begin
          r.delay_index = i[INDEX_BITS-1:0];
          r.status = STATUS_FOUND;
          break;
        end
      end
    end
    awaited_results = {awaited_results, r};
    window_peak = '0;
    window_fill = 0;
    window_overflow = 1'b0;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_value,
                                        logic [31:0] act_value);
    if (act_value !== exp_value) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_value,
               act_value);
      error_count++;
    end
  endfunction

  // Queues one sample word. A quiet word follows its predecessor with no gap;
  // a drain word is held back until every owed result has arrived.
  function automatic void queue_sample(logic signed [SAMPLE_BITS-1:0] value, bit last,
                                       bit quiet = 1'b0, bit drain = 1'b0);
    queued_word_t q;
    q.word.sample = value;
    q.word.last = last;
    q.gap = quiet ? 0 : $urandom_range(0, 15);
    q.drain = drain;
    sample_backlog = {sample_backlog, q};
    samples_queued++;
  endfunction

  // A random value whose magnitude is limited to the given number of bits.
  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(int unsigned bits);
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    return v >>> (SAMPLE_BITS - bits);
  endfunction

  // A captured response: low-level noise up to the onset position, then a
  // loud burst. Now and then a word is pinned to full scale or zero.
  function automatic void queue_window(int unsigned len, int unsigned onset, bit quiet,
                                       bit drain);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int unsigned i = 0; i < len; i++) begin
      if (i < onset) begin
        s = draw_sample($urandom_range(1, 10));
      end else begin
        s = draw_sample($urandom_range(10, SAMPLE_BITS));
      end
      case ($urandom_range(0, 31))
        0: s = FULL_POS;
        1: s = FULL_NEG;
        2: s = '0;
        default: ;
      endcase
      queue_sample(s, i == len - 1, quiet, drain && i == 0);
    end
  endfunction

  // Registers are only written here, with the core idle.
  task automatic program_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_THRESHOLD: model_fraction = data[FRAC_BITS-1:0];
      CFG_MIN_PEAK:  model_min_peak = data[PEAK_BITS-1:0];
      default: ;
    endcase
    register_writes++;
  endtask

  // Waits until every queued word has been taken and every owed result has
  // come back. Each phase ends on a last word, so the core is then back at
  // rest; a spare wait follows.
  task automatic settle();
    while (sample_backlog.size() != 0 || sample_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // Sender. The valid is held through stalls and, when the next word is
  // ready with no gap, simply stays high into the next word.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      idle_count = 0;
    end else if (!(sample_valid && sample_stall)) begin
      if (sample_valid) begin
        absorb_sample(sample_word);
        samples_taken++;
      end
      if (sample_backlog.size() != 0 && idle_count >= sample_backlog[0].gap &&
          !(sample_backlog[0].drain && awaited_results.size() != 0)) begin
        next_word = sample_backlog.pop_front();
        sample_word <= next_word.word;
        sample_valid <= 1'b1;
        idle_count = 0;
      end else begin
        sample_valid <= 1'b0;
        if (sample_backlog.size() != 0) begin
          idle_count++;
        end
      end
    end
  end

  // Receiver. Unless quiet, it stalls for a random stretch after each result
  // word, so that finished results sometimes wait in the output register
  // while the next window is loading.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with none expected, actual %p", $time, result_word);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("delay_index", 32'(want.delay_index),
                        32'(result_word.delay_index));
          compare_field("peak_value", 32'(want.peak_value), 32'(result_word.peak_value));
          compare_field("status", 32'(want.status), 32'(result_word.status));
          compare_field("truncated", 32'(want.truncated), 32'(result_word.truncated));
          windows_checked++;
          case (want.status)
            STATUS_FOUND: onsets_seen++;
            STATUS_WEAK:  weak_seen++;
            default:      uncrossed_seen++;
          endcase
          if (want.truncated) begin
            truncated_seen++;
          end
        end
        hold_count = rx_quiet ? 0 : $urandom_range(0, 15);
      end else if (hold_count != 0) begin
        hold_count--;
      end
      result_stall <= (hold_count != 0);
    end
  end

  initial begin
    int unsigned          len;
    int unsigned          onset;
    int unsigned          phase_items;
    logic [FRAC_BITS-1:0] frac;
    logic [6:0]           spare;
    logic [PEAK_BITS-1:0] min_value;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first windows run on the reset settings: full-scale
    // words of both signs, a peak one below the minimum and one exactly at it.
    queue_sample(24'sd0, 1'b0);
    queue_sample(FULL_POS, 1'b0);
    queue_sample(FULL_NEG, 1'b0);
    queue_sample(24'sd5, 1'b1);
    queue_sample(24'sd7, 1'b1, 1'b0, 1'b1);
    queue_sample(-24'sd8, 1'b1);
    settle();

    // A zero fraction puts the onset on the first word of any passing window,
    // and with no minimum even an all-zero window passes.
    program_register(CFG_THRESHOLD, 24'd0);
    queue_sample(24'sd1, 1'b0);
    queue_sample(24'sd100, 1'b0);
    queue_sample(24'sd9, 1'b1);
    settle();
    program_register(CFG_MIN_PEAK, 24'd0);
    queue_sample(24'sd0, 1'b0);
    queue_sample(24'sd0, 1'b1);
    settle();

    // A fraction of exactly one finds the first word equal to the peak.
    program_register(CFG_THRESHOLD, 24'd65536);
    program_register(CFG_MIN_PEAK, 24'd1);
    queue_sample(24'sd3, 1'b0);
    queue_sample(-24'sd50, 1'b0);
    queue_sample(24'sd50, 1'b0);
    queue_sample(24'sd49, 1'b1);
    settle();

    // Fractions above one leave no word crossing; the spare upper bits of the
    // written value must be dropped.
    program_register(CFG_THRESHOLD, 24'hFFFFFF);
    queue_sample(24'sd10, 1'b0);
    queue_sample(-24'sd20, 1'b0);
    queue_sample(24'sd20, 1'b1);
    settle();
    program_register(CFG_THRESHOLD, 24'd65537);
    queue_sample(FULL_NEG, 1'b1);
    settle();

    // Largest minimum rejects even full scale; a minimum of full scale
    // accepts the most negative word.
    program_register(CFG_THRESHOLD, 24'd49152);
    program_register(CFG_MIN_PEAK, 24'hFFFFFF);
    queue_sample(FULL_NEG, 1'b0);
    queue_sample(FULL_POS, 1'b1);
    settle();
    program_register(CFG_MIN_PEAK, 24'h800000);
    queue_sample(FULL_NEG, 1'b1);
    settle();

    // Random part: phases of realistic windows, each under fresh settings.
    for (int phase = 0; phase < 10; phase++) begin
      rx_quiet = (phase % 4 == 3);
      case ($urandom_range(0, 9))
        0: frac = '0;
        1: frac = 17'd65536;
        2: frac = FRAC_BITS'($urandom_range(65537, 131071));
        3: frac = 17'd49152;
        default: frac = FRAC_BITS'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 9))
        0: min_value = '0;
        1: min_value = 24'h800000;
        2: min_value = 24'hFFFFFF;
        3: min_value = PEAK_BITS'($urandom_range(0, 24'hFFFFFF));
        default: min_value = PEAK_BITS'($urandom_range(0, 1 << $urandom_range(0, 16)));
      endcase
      spare = 7'($urandom);
      program_register(CFG_THRESHOLD, {spare, frac});
      program_register(CFG_MIN_PEAK, min_value);
      phase_items = 0;
      while (phase_items < 95) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 400) : $urandom_range(1, 40);
        // One window in four has its onset at the first word, so it is loud throughout.
        onset = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, len - 1);
        queue_window(len, onset, $urandom_range(0, 4) == 0, $urandom_range(0, 7) == 0);
        phase_items += len;
      end
      settle();
    end

    repeat (40) @(posedge clk);
    $display("Sent %0d sample words in %0d windows over %0d register writes.",
             samples_taken, windows_checked, register_writes);
    $display("Onsets %0d, weak %0d, no crossing %0d, truncated %0d, mismatches %0d.",
             onsets_seen, weak_seen, uncrossed_seen, truncated_seen, error_count);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/odd_pkg.sv
rtl/core/odd_ram.sv
rtl/core/odd_ctrl.sv
rtl/core/odd_datapath.sv
rtl/core/onset_delay_detector_core.sv
test/onset_delay_detector_core_tb.sv
